// ----- src/taft_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the triangle affine transform unit.
// No dependencies; imported by the top level and its port checker.
package taft_pkg;

    localparam int NUM_VERTICES       = 3;
    localparam int COORD_BITS_DEFAULT = 16;
    localparam int IO_COORD_W         = 16;
    localparam int VIDX_W             = 2;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    typedef enum logic [2:0] {
        CMD_LOAD      = 3'd0,
        CMD_TRANSLATE = 3'd1,
        CMD_SCALE     = 3'd2,
        CMD_MIRROR    = 3'd3,
        CMD_SHEAR     = 3'd4,
        CMD_ROTATE    = 3'd5
    } cmd_t;

    localparam logic [1:0] AXIS_X      = 2'd0;
    localparam logic [1:0] AXIS_Y      = 2'd1;
    localparam logic [1:0] INVALID_SEL = 2'd3;

    localparam logic [VIDX_W-1:0] VIDX_LAST = VIDX_W'(NUM_VERTICES - 1);

    // Coefficient width: Q1.15 sine/cosine including the exact +/-1.0 value.
    localparam int COEF_W = 17;

    // Angle reduction: bias by 92 turns so the value is never negative, then
    // take the quotient by 360 through a reciprocal multiply.
    localparam int ANGLE_U_W         = 17;
    localparam int ANGLE_BIAS        = 33120;
    localparam int ANGLE_RECIP       = 46604;
    localparam int ANGLE_RECIP_SHIFT = 24;
    localparam int ANGLE_Q_W         = 8;
    localparam int ANGLE_W           = 9;

    localparam int DEG_90  = 90;
    localparam int DEG_180 = 180;
    localparam int DEG_270 = 270;
    localparam int DEG_360 = 360;

    localparam int Q15_SHIFT = 15;
    localparam int Q15_HALF  = 16384;

    localparam int VX_INIT [NUM_VERTICES] = '{300, 500, 400};
    localparam int VY_INIT [NUM_VERTICES] = '{340, 340, 140};

    localparam logic [15:0] SIN_Q15 [91] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
        16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
        16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
        16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
        16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
        16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
        16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
        16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
        16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
        16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
        16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
    };

    // Sine of a whole angle 0..359 in Q1.15, folded onto the quarter table.
    function automatic logic signed [COEF_W-1:0] sin_deg(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0]       idx;
        logic                     neg;
        logic signed [COEF_W-1:0] mag;
        if (a <= ANGLE_W'(DEG_90)) begin
            idx = a;
            neg = 1'b0;
        end else if (a <= ANGLE_W'(DEG_180)) begin
            idx = ANGLE_W'(DEG_180) - a;
            neg = 1'b0;
        end else if (a <= ANGLE_W'(DEG_270)) begin
            idx = a - ANGLE_W'(DEG_180);
            neg = 1'b1;
        end else begin
            idx = ANGLE_W'(DEG_360) - a;
            neg = 1'b1;
        end
        mag = signed'({1'b0, SIN_Q15[idx[6:0]]});
        return neg ? -mag : mag;
    endfunction

endpackage

// ----- src/triangle_affine_transform_unit.sv -----
`timescale 1ns / 1ps
// Triangle affine transform unit: three stored vertices, one command per request,
// three result requests out (vertex 0, 1, 2; the third carries tlast). Uses taft_pkg.
// Load and invalid requests skip the arithmetic; translate, scale, mirror and shear take
// one product per coordinate, and rotate reduces the angle, then takes two, all on one
// shared 17-bit-coefficient multiplier that runs one product at a time.
// Reset (aresetn low, synchronous) restores the vertex triangle and empties the output.
module triangle_affine_transform_unit #(
    parameter int COORD_BITS = taft_pkg::COORD_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input requests
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [taft_pkg::S_TDATA_W-1:0] s_tdata,   // param_a, param_b, angle_deg
    input  logic [taft_pkg::S_TUSER_W-1:0] s_tuser,   // cmd[2:0], ref_select[4:3]
    // result requests
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [taft_pkg::M_TDATA_W-1:0] m_tdata,   // vertex_x_out, vertex_y_out
    output logic [taft_pkg::M_TUSER_W-1:0] m_tuser,   // vertex_index[1:0], status[2]
    output logic                           m_tlast
);
    import taft_pkg::*;

    // Multiplier operand A must hold a coordinate difference and the biased angle.
    localparam int A_W    = (COORD_BITS + 1 > ANGLE_U_W + 1) ? COORD_BITS + 1 : ANGLE_U_W + 1;
    localparam int PROD_W = A_W + COEF_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int FIN_W  = ACC_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE,     // take a request
        ST_ANG_MUL,  // biased angle times reciprocal of 360
        ST_ANG_REM,  // remainder by 360
        ST_TRIG,     // sine and cosine lookup
        ST_OPND,     // register multiplier operands
        ST_MUL,      // one product
        ST_ACC,      // accumulate product
        ST_ROUND,    // Q1.15 round half away from zero
        ST_FIN,      // add offset, saturate, write coordinate
        ST_EMIT      // hand vertex to output register
    } state_t;

    state_t state_reg;

    // Vertex store
    logic signed [COORD_BITS-1:0] vx_reg [NUM_VERTICES];
    logic signed [COORD_BITS-1:0] vy_reg [NUM_VERTICES];

    // Request fields held for the whole command
    cmd_t                    cmd_reg;
    logic [1:0]              sel_reg;
    logic signed [15:0]      pa_reg;
    logic signed [15:0]      pb_reg;
    logic                    bad_reg;
    logic                    compute_reg;
    logic signed [COORD_BITS-1:0] xr_reg;
    logic signed [COORD_BITS-1:0] yr_reg;
    logic signed [COORD_BITS-1:0] xold_reg;
    logic [ANGLE_W-1:0]      ang_reg;
    logic signed [COEF_W-1:0] s_reg;
    logic signed [COEF_W-1:0] c_reg;

    // Sequencer position
    logic [VIDX_W-1:0]       vidx_reg;
    logic                    coord_reg;   // 0 x, 1 y
    logic                    term_reg;    // product number within a coordinate

    // Shared arithmetic unit
    logic signed [A_W-1:0]    opa_reg;
    logic signed [COEF_W-1:0] opb_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // Output register
    logic                    m_tvalid_reg;
    logic signed [IO_COORD_W-1:0] mx_reg;
    logic signed [IO_COORD_W-1:0] my_reg;
    logic [VIDX_W-1:0]       midx_reg;
    logic                    mstatus_reg;
    logic                    mlast_reg;

    // Input field unpacking
    logic [2:0]         s_cmd;
    logic [1:0]         s_sel;
    logic signed [15:0] s_param_a;
    logic signed [15:0] s_param_b;
    logic signed [15:0] s_angle;
    logic               s_bad;
    logic               s_compute;
    logic signed [ANGLE_U_W:0] ang_wide;

    assign s_cmd     = s_tuser[2:0];
    assign s_sel     = s_tuser[4:3];
    assign s_param_a = s_tdata[15:0];
    assign s_param_b = s_tdata[31:16];
    assign s_angle   = s_tdata[47:32];

    // Translate ignores the reference; every other valid command rejects code 3.
    assign s_bad     = (s_cmd > CMD_ROTATE) || ((s_cmd != CMD_TRANSLATE) && (s_sel == INVALID_SEL));
    assign s_compute = !s_bad && (s_cmd != CMD_LOAD);
    assign ang_wide  = (ANGLE_U_W + 1)'(s_angle) + (ANGLE_U_W + 1)'(ANGLE_BIAS);

    function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [FIN_W-1:0] v);
        logic ovf;
        ovf = (v[FIN_W-1:COORD_BITS-1] != '0) && (v[FIN_W-1:COORD_BITS-1] != '1);
        if (!ovf) begin
            return v[COORD_BITS-1:0];
        end else if (v[FIN_W-1]) begin
            return {1'b1, {(COORD_BITS - 1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_BITS - 1){1'b1}}};
        end
    endfunction

    // Current vertex and differences to the reference vertex
    logic signed [COORD_BITS-1:0] x_cur;
    logic signed [COORD_BITS-1:0] y_cur;
    logic signed [COORD_BITS-1:0] x_src;
    logic signed [A_W-1:0]        dx;
    logic signed [A_W-1:0]        dy;
    logic signed [A_W-1:0]        opa_sel;
    logic signed [COEF_W-1:0]     opb_sel;
    logic signed [FIN_W-1:0]      off_sel;
    logic                         x_active;
    logic                         y_active;

    assign x_cur = vx_reg[vidx_reg];
    assign y_cur = vy_reg[vidx_reg];
    // In the y pass, dx works from the x value before this command touched it.
    assign x_src = coord_reg ? xold_reg : x_cur;
    assign dx    = A_W'(x_src) - A_W'(xr_reg);
    assign dy    = A_W'(y_cur) - A_W'(yr_reg);

    // Axis modes for mirror and shear
    assign x_active = (sel_reg != AXIS_Y);
    assign y_active = (sel_reg != AXIS_X);

    // Operand and offset selection per command, coordinate and term
    always_comb begin
        opa_sel = A_W'(x_cur);
        opb_sel = COEF_W'(1);
        off_sel = '0;
        case (cmd_reg)
            CMD_TRANSLATE: begin
                opa_sel = coord_reg ? A_W'(y_cur) : A_W'(x_cur);
                off_sel = coord_reg ? FIN_W'(pb_reg) : FIN_W'(pa_reg);
            end
            CMD_SCALE: begin
                opa_sel = coord_reg ? dy : dx;
                opb_sel = coord_reg ? COEF_W'(pb_reg) : COEF_W'(pa_reg);
                off_sel = coord_reg ? FIN_W'(yr_reg) : FIN_W'(xr_reg);
            end
            CMD_MIRROR: begin
                opa_sel = coord_reg ? A_W'(y_cur) : A_W'(x_cur);
                if (coord_reg ? y_active : x_active) begin
                    opb_sel = COEF_W'(-1);
                end
            end
            CMD_SHEAR: begin
                // y pass multiplies the freshly written x
                opa_sel = coord_reg ? A_W'(x_cur) : A_W'(y_cur);
                if (coord_reg ? y_active : x_active) begin
                    opb_sel = coord_reg ? COEF_W'(pb_reg) : COEF_W'(pa_reg);
                end else begin
                    opb_sel = '0;
                end
                off_sel = coord_reg ? FIN_W'(y_cur) : FIN_W'(x_cur);
            end
            CMD_ROTATE: begin
                // x = dx*c - dy*s, y = dx*s + dy*c
                opa_sel = term_reg ? dy : dx;
                if (coord_reg) begin
                    opb_sel = term_reg ? c_reg : s_reg;
                end else begin
                    opb_sel = term_reg ? -s_reg : c_reg;
                end
                off_sel = coord_reg ? FIN_W'(yr_reg) : FIN_W'(xr_reg);
            end
            default: begin
                opa_sel = A_W'(x_cur);
            end
        endcase
    end

    // Shared multiplier and its helpers
    logic signed [PROD_W-1:0]    prod_mul;
    logic signed [ACC_W-1:0]     acc_rnd;
    logic signed [FIN_W-1:0]     fin_sum;
    logic signed [COORD_BITS-1:0] fin_coord;
    logic [ANGLE_Q_W-1:0]        ang_q;
    logic [ANGLE_U_W-1:0]        ang_rem;
    logic [ANGLE_W-1:0]          cos_arg;

    assign prod_mul  = opa_reg * opb_reg;
    assign acc_rnd   = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'(Q15_HALF - 1) : ACC_W'(Q15_HALF));
    assign fin_sum   = FIN_W'(acc_reg) + off_sel;
    assign fin_coord = sat_coord(fin_sum);
    assign ang_q     = prod_reg[ANGLE_RECIP_SHIFT +: ANGLE_Q_W];
    assign ang_rem   = opa_reg[ANGLE_U_W-1:0] - ANGLE_U_W'(ang_q) * ANGLE_U_W'(DEG_360);
    assign cos_arg   = (ang_reg >= ANGLE_W'(DEG_270)) ? ang_reg - ANGLE_W'(DEG_270)
                                                      : ang_reg + ANGLE_W'(DEG_90);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_VERTICES; i++) begin
                vx_reg[i] <= COORD_BITS'(VX_INIT[i]);
                vy_reg[i] <= COORD_BITS'(VY_INIT[i]);
            end
        end else begin
            // drop the output once taken; EMIT handles the output register itself
            if (m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg     <= cmd_t'(s_cmd);
                        sel_reg     <= s_sel;
                        pa_reg      <= s_param_a;
                        pb_reg      <= s_param_b;
                        bad_reg     <= s_bad;
                        compute_reg <= s_compute;
                        vidx_reg    <= '0;
                        coord_reg   <= 1'b0;
                        term_reg    <= 1'b0;
                        if (s_sel != INVALID_SEL) begin
                            xr_reg <= vx_reg[s_sel];
                            yr_reg <= vy_reg[s_sel];
                        end
                        // angle reduction operands
                        opa_reg <= A_W'(ang_wide);
                        opb_reg <= COEF_W'(ANGLE_RECIP);
                        if (!s_bad && (s_cmd == CMD_LOAD)) begin
                            vx_reg[s_sel] <= sat_coord(FIN_W'(s_param_a));
                            vy_reg[s_sel] <= sat_coord(FIN_W'(s_param_b));
                        end
                        if (s_compute && (s_cmd == CMD_ROTATE)) begin
                            state_reg <= ST_ANG_MUL;
                        end else if (s_compute) begin
                            state_reg <= ST_OPND;
                        end else begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_ANG_MUL: begin
                    prod_reg  <= prod_mul;
                    state_reg <= ST_ANG_REM;
                end
                ST_ANG_REM: begin
                    // one correction step covers any reciprocal error
                    if (ang_rem >= ANGLE_U_W'(DEG_360)) begin
                        ang_reg <= ANGLE_W'(ang_rem - ANGLE_U_W'(DEG_360));
                    end else begin
                        ang_reg <= ANGLE_W'(ang_rem);
                    end
                    state_reg <= ST_TRIG;
                end
                ST_TRIG: begin
                    s_reg     <= sin_deg(ang_reg);
                    c_reg     <= sin_deg(cos_arg);
                    state_reg <= ST_OPND;
                end
                ST_OPND: begin
                    opa_reg   <= opa_sel;
                    opb_reg   <= opb_sel;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= prod_mul;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg <= (term_reg ? acc_reg : '0) + ACC_W'(prod_reg);
                    if ((cmd_reg == CMD_ROTATE) && !term_reg) begin
                        term_reg  <= 1'b1;
                        state_reg <= ST_OPND;
                    end else if (cmd_reg == CMD_ROTATE) begin
                        state_reg <= ST_ROUND;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_ROUND: begin
                    acc_reg   <= acc_rnd >>> Q15_SHIFT;
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    term_reg <= 1'b0;
                    if (!coord_reg) begin
                        xold_reg         <= x_cur;
                        vx_reg[vidx_reg] <= fin_coord;
                        coord_reg        <= 1'b1;
                        state_reg        <= ST_OPND;
                    end else begin
                        vy_reg[vidx_reg] <= fin_coord;
                        state_reg        <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        mx_reg       <= IO_COORD_W'(x_cur);
                        my_reg       <= IO_COORD_W'(y_cur);
                        midx_reg     <= vidx_reg;
                        mstatus_reg  <= bad_reg;
                        mlast_reg    <= (vidx_reg == VIDX_LAST);
                        if (vidx_reg == VIDX_LAST) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            vidx_reg  <= vidx_reg + VIDX_W'(1);
                            coord_reg <= 1'b0;
                            term_reg  <= 1'b0;
                            state_reg <= compute_reg ? ST_OPND : ST_EMIT;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {my_reg, mx_reg};
    assign m_tuser  = {mstatus_reg, midx_reg};
    assign m_tlast  = mlast_reg;

endmodule

// ----- src/taft_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the triangle affine transform unit, bound to the top level.
// Depends on taft_pkg and triangle_affine_transform_unit.
module taft_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [taft_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [taft_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [taft_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [taft_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                           m_tlast
);
    import taft_pkg::*;

    // one request in flight: busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a request");

    // output register empties on reset
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // tlast marks exactly the last vertex, and no index beyond it
    a_last_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser[VIDX_W-1:0] == VIDX_LAST)) &&
                     (m_tuser[VIDX_W-1:0] <= VIDX_LAST))
        else $error("tlast or vertex index wrong");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // vertex index advances by one after a non-last result is taken
    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            !m_tvalid || (m_tuser[VIDX_W-1:0] == $past(m_tuser[VIDX_W-1:0]) + VIDX_W'(1)))
        else $error("vertex results out of order");

endmodule

bind triangle_affine_transform_unit taft_checker u_taft_checker (.*);
